// File: hw/rtl/bpdc_pkg.sv
// ----------------------------------------------------------------------------
// bpdc_pkg
// Types, register map constants and lane helpers for the backlight
// PWM / dimmer controller.
// ----------------------------------------------------------------------------
package bpdc_pkg;

  typedef enum logic [2:0] {
    CMD_PWM_RD  = 3'd0,
    CMD_PWM_WR  = 3'd1,
    CMD_DIM_RD  = 3'd2,
    CMD_DIM_WR  = 3'd3,
    CMD_GPIO_EV = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_DEFAULT = 2'd0,
    MODE_PWM     = 2'd1,
    MODE_DIMMER  = 2'd2
  } mode_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] offset;
    logic [2:0]  access_size;
    logic [31:0] write_data;
    logic [11:0] gpio_addr;
    logic [31:0] gpio_write_mask;
    logic [31:0] gpio_output_value;
  } in_word_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [1:0]  mode;
    logic        powered;
    logic [5:0]  level;
    logic [7:0]  intensity;
    logic [31:0] change_count;
    logic [31:0] pulse_count;
    logic [31:0] up_count;
    logic [31:0] down_count;
  } out_word_t;

  // state the view logic needs to derive mode / power / level
  typedef struct packed {
    logic       dimmer_touched;
    logic       pwm_touched;
    logic       power_event_seen;
    logic       power_on;
    logic [5:0] dim_level;
    logic       pwm_en;
    logic [7:0] duty;
  } view_state_t;

  localparam logic [13:0] PWM_BL_IDX    = 14'd4;
  localparam logic [13:0] DIM_CFG_IDX   = 14'd0;
  localparam logic [13:0] DIM_STAT_IDX  = 14'd1;
  localparam logic [5:0]  DIM_WIDTH_IDX = 6'd8;
  localparam int          DIM_START_BIT = 30;
  localparam int          DIM_BUSY_BIT  = 31;
  localparam int          PWM_EN_BIT    = 31;
  localparam logic [7:0]  DIM_CHAN      = 8'd8;
  localparam logic [31:0] UP_WIDTH      = 32'd127;
  localparam logic [31:0] DOWN_WIDTH    = 32'd1;
  localparam logic [11:0] GPIO_OUT_REG  = 12'h12c;
  localparam int          GPIO_BL_BIT   = 7;
  localparam logic [5:0]  SEED_LEVEL    = 6'd16;
  localparam logic [5:0]  MAX_LEVEL     = 6'd32;
  localparam logic [7:0]  INTEN_BASE    = 8'd48;
  localparam logic [7:0]  INTEN_SLOPE   = 8'd207;
  localparam logic [7:0]  DUTY_DIRECT   = 8'd32;
  localparam logic [13:0] DUTY_ROUND    = 14'd127;

  function automatic logic [31:0] lane_mask(input logic [2:0] size);
    logic [31:0] m;
    unique case (size)
      3'd1:    m = 32'h0000_00ff;
      3'd2:    m = 32'h0000_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

  function automatic logic [31:0] lane_extract(input logic [31:0] word,
                                               input logic [1:0]  lane,
                                               input logic [2:0]  size);
    logic [4:0] sh;
    sh = {lane, 3'b000};
    return (word >> sh) & lane_mask(size);
  endfunction

  // lanes shifted past bit 31 fall off
  function automatic logic [31:0] lane_merge(input logic [31:0] old,
                                             input logic [1:0]  lane,
                                             input logic [2:0]  size,
                                             input logic [31:0] data);
    logic [4:0]  sh;
    logic [31:0] m;
    sh = {lane, 3'b000};
    m  = lane_mask(size) << sh;
    return (old & ~m) | ((data << sh) & m);
  endfunction

endpackage

// File: hw/rtl/backlight_pwm_dimmer_controller_unit.sv
// ----------------------------------------------------------------------------
// backlight_pwm_dimmer_controller_unit
// Register access engine for a PWM bank and a dimmer bank, with start-pulse
// level stepping, GPIO power events and a backlight view on every result.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | word
//  --------+-----+--------------------+------------------------------------
//  in_     | in  | in_valid/in_stall   | in_word  (access or gpio event)
//  out_    | out | out_valid/out_stall | out_word (read data + view)
//
//  One word per cycle sustained while the output does not stall; out_valid is
//  registered from stage 1 after the accept. Stage 0 reads the bank RAM and updates
//  the dimmer config register; stage 1 merges / writes back and registers the result.
//  A write in the previous commit is forwarded to a read of the same entry.
//  Per-entry valid bits make both banks read as zero after reset, no sweep.
//  A stalled output holds the second stage, which back-pressures the input.
// ----------------------------------------------------------------------------
module backlight_pwm_dimmer_controller_unit #(
  parameter int PWM_WORDS    = 8,
  parameter int DIMMER_WORDS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bpdc_pkg::in_word_t   in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bpdc_pkg::out_word_t  out_word
);
  import bpdc_pkg::*;

  localparam int PAW = $clog2(PWM_WORDS);
  localparam int DAW = $clog2(DIMMER_WORDS);

  // ---------------- stage 0: accept, read issue, config register
  logic        in_accept;
  logic        s1_fire;
  logic        out_ready;
  logic [13:0] idx0;
  logic        pok0, dok0;
  logic        cfg_wr0;
  logic [31:0] cfg_new0;
  logic [5:0]  widx0;
  logic        wok0;
  logic        pulse0;
  logic [DAW-1:0] daddr0;

  logic [31:0] cfg_r;

  assign in_accept = in_valid && !in_stall;
  assign idx0      = in_word.offset[15:2];
  assign pok0      = idx0 < 14'(PWM_WORDS);
  assign dok0      = idx0 < 14'(DIMMER_WORDS);
  assign cfg_wr0   = (cmd_e'(in_word.command) == CMD_DIM_WR) && dok0 && (idx0 == DIM_CFG_IDX);
  assign cfg_new0  = lane_merge(cfg_r, in_word.offset[1:0], in_word.access_size,
                                in_word.write_data);
  assign pulse0    = cfg_wr0 && !cfg_r[DIM_START_BIT] && cfg_new0[DIM_START_BIT];
  // one width word per group of 8 channels
  assign widx0     = DIM_WIDTH_IDX + {1'b0, cfg_new0[7:3]};
  assign wok0      = {1'b0, widx0} < 7'(DIMMER_WORDS);
  assign daddr0    = cfg_wr0 ? widx0[DAW-1:0] : idx0[DAW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (in_accept && cfg_wr0) begin
      cfg_r <= cfg_new0;
    end
  end

  // ---------------- stage 1 registers
  logic           s1_vld_r;
  cmd_e           s1_cmd_r;
  logic [1:0]     s1_lane_r;
  logic [2:0]     s1_size_r;
  logic [31:0]    s1_data_r;
  logic           s1_pok_r, s1_dok_r;
  logic [PAW-1:0] s1_paddr_r;
  logic [DAW-1:0] s1_daddr_r;
  logic           s1_is_bl_r, s1_is_cfg_r, s1_is_stat_r;
  logic [31:0]    s1_cfg_rd_r;
  logic           s1_pulse_r, s1_chan8_r, s1_wok_r;
  logic           s1_gact_r, s1_gval_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_accept) begin
      s1_vld_r <= 1'b1;
    end else if (s1_fire) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cmd_r     <= cmd_e'(in_word.command);
      s1_lane_r    <= in_word.offset[1:0];
      s1_size_r    <= in_word.access_size;
      s1_data_r    <= in_word.write_data;
      s1_pok_r     <= pok0;
      s1_dok_r     <= dok0;
      s1_paddr_r   <= idx0[PAW-1:0];
      s1_daddr_r   <= daddr0;
      s1_is_bl_r   <= idx0 == PWM_BL_IDX;
      s1_is_cfg_r  <= idx0 == DIM_CFG_IDX;
      s1_is_stat_r <= idx0 == DIM_STAT_IDX;
      s1_cfg_rd_r  <= cfg_r;
      s1_pulse_r   <= pulse0;
      s1_chan8_r   <= cfg_new0[7:0] == DIM_CHAN;
      s1_wok_r     <= wok0;
      s1_gact_r    <= (in_word.gpio_addr == GPIO_OUT_REG) &&
                      in_word.gpio_write_mask[GPIO_BL_BIT];
      s1_gval_r    <= in_word.gpio_output_value[GPIO_BL_BIT];
    end
  end

  // ---------------- bank memories
  logic           pwe, dwe;
  logic [31:0]    pwdata, dwdata;
  logic [31:0]    pq, dq;

  bpdc_ram #(.WIDTH(32), .DEPTH(PWM_WORDS)) u_pwm_ram (
    .clk   (clk),
    .we    (pwe),
    .waddr (s1_paddr_r),
    .wdata (pwdata),
    .re    (in_accept),
    .raddr (idx0[PAW-1:0]),
    .rdata (pq)
  );

  bpdc_ram #(.WIDTH(32), .DEPTH(DIMMER_WORDS)) u_dim_ram (
    .clk   (clk),
    .we    (dwe),
    .waddr (s1_daddr_r),
    .wdata (dwdata),
    .re    (in_accept),
    .raddr (daddr0),
    .rdata (dq)
  );

  // valid bits and last-write forwarding
  logic [PWM_WORDS-1:0]    pvld_r;
  logic [DIMMER_WORDS-1:0] dvld_r;
  logic                    pfw_vld_r, dfw_vld_r;
  logic [PAW-1:0]          pfw_addr_r;
  logic [DAW-1:0]          dfw_addr_r;
  logic [31:0]             pfw_data_r, dfw_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvld_r    <= '0;
      dvld_r    <= '0;
      pfw_vld_r <= 1'b0;
      dfw_vld_r <= 1'b0;
    end else if (s1_fire) begin
      pfw_vld_r <= pwe;
      dfw_vld_r <= dwe;
      if (pwe) begin
        pvld_r[s1_paddr_r] <= 1'b1;
      end
      if (dwe) begin
        dvld_r[s1_daddr_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      pfw_addr_r <= s1_paddr_r;
      pfw_data_r <= pwdata;
      dfw_addr_r <= s1_daddr_r;
      dfw_data_r <= dwdata;
    end
  end

  logic [31:0] pold, dold;

  always_comb begin
    if (pfw_vld_r && pfw_addr_r == s1_paddr_r) begin
      pold = pfw_data_r;
    end else if (pvld_r[s1_paddr_r]) begin
      pold = pq;
    end else begin
      pold = '0;
    end
    if (dfw_vld_r && dfw_addr_r == s1_daddr_r) begin
      dold = dfw_data_r;
    end else if (dvld_r[s1_daddr_r]) begin
      dold = dq;
    end else begin
      dold = '0;
    end
  end

  // ---------------- stage 1: modify / write back
  logic        pwm_touched_r, dimmer_touched_r, power_event_seen_r, power_on_r;
  logic [5:0]  dim_level_r;
  logic        busy_r;
  logic [31:0] pw_r;
  logic [31:0] generation_r, pulse_total_r, up_total_r, down_total_r;

  logic        pwm_touched_nxt, dimmer_touched_nxt, power_event_seen_nxt, power_on_nxt;
  logic [5:0]  dim_level_nxt;
  logic        busy_nxt;
  logic [31:0] pw_nxt;
  logic [31:0] generation_nxt, pulse_total_nxt, up_total_nxt, down_total_nxt;
  logic [31:0] rd;
  logic [31:0] pmerged, dmerged, dword, width;
  logic [5:0]  base_level;

  assign pmerged    = lane_merge(pold, s1_lane_r, s1_size_r, s1_data_r);
  assign dmerged    = lane_merge(dold, s1_lane_r, s1_size_r, s1_data_r);
  assign width      = s1_wok_r ? dold : 32'd0;
  assign base_level = dimmer_touched_r ? dim_level_r : SEED_LEVEL;

  always_comb begin
    pwm_touched_nxt      = pwm_touched_r;
    dimmer_touched_nxt   = dimmer_touched_r;
    power_event_seen_nxt = power_event_seen_r;
    power_on_nxt         = power_on_r;
    dim_level_nxt        = dim_level_r;
    busy_nxt             = busy_r;
    pw_nxt               = pw_r;
    generation_nxt       = generation_r;
    pulse_total_nxt      = pulse_total_r;
    up_total_nxt         = up_total_r;
    down_total_nxt       = down_total_r;
    rd                   = '0;
    pwe                  = 1'b0;
    dwe                  = 1'b0;
    pwdata               = pmerged;
    dwdata               = dmerged;
    dword                = dold;

    unique case (s1_cmd_r)
      CMD_PWM_RD: begin
        if (s1_pok_r) begin
          rd = lane_extract(pold, s1_lane_r, s1_size_r);
        end
      end
      CMD_PWM_WR: begin
        if (s1_pok_r) begin
          pwe = 1'b1;
          if (s1_is_bl_r) begin
            pwm_touched_nxt = 1'b1;
            pw_nxt          = pmerged;
            if (pmerged != pold) begin
              generation_nxt = generation_r + 32'd1;
            end
          end
        end
      end
      CMD_DIM_RD: begin
        if (s1_dok_r) begin
          if (s1_is_cfg_r) begin
            dword = s1_cfg_rd_r;
          end else if (s1_is_stat_r) begin
            dword    = {busy_r, 31'd0};
            busy_nxt = 1'b0;   // read-to-clear, after returning the set bit
          end
          rd = lane_extract(dword, s1_lane_r, s1_size_r);
        end
      end
      CMD_DIM_WR: begin
        if (s1_dok_r) begin
          if (s1_is_stat_r) begin
            busy_nxt = 1'b0;
          end else if (!s1_is_cfg_r) begin
            dwe = 1'b1;
          end
          if (s1_pulse_r) begin
            dimmer_touched_nxt = 1'b1;
            dim_level_nxt      = base_level;
            pulse_total_nxt    = pulse_total_r + 32'd1;
            generation_nxt     = generation_r + 32'd1;
            busy_nxt           = 1'b1;
            if (s1_chan8_r && width == UP_WIDTH) begin
              if (base_level < MAX_LEVEL) begin
                dim_level_nxt = base_level + 6'd1;
              end
              up_total_nxt = up_total_r + 32'd1;
            end else if (s1_chan8_r && width == DOWN_WIDTH) begin
              if (base_level != 6'd0) begin
                dim_level_nxt = base_level - 6'd1;
              end
              down_total_nxt = down_total_r + 32'd1;
            end
          end
        end
      end
      CMD_GPIO_EV: begin
        if (s1_gact_r) begin
          if (!power_event_seen_r || s1_gval_r != power_on_r) begin
            generation_nxt = generation_r + 32'd1;
          end
          power_event_seen_nxt = 1'b1;
          power_on_nxt         = s1_gval_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_touched_r      <= 1'b0;
      dimmer_touched_r   <= 1'b0;
      power_event_seen_r <= 1'b0;
      power_on_r         <= 1'b0;
      dim_level_r        <= '0;
      busy_r             <= 1'b0;
      pw_r               <= '0;
      generation_r       <= '0;
      pulse_total_r      <= '0;
      up_total_r         <= '0;
      down_total_r       <= '0;
    end else if (s1_fire) begin
      pwm_touched_r      <= pwm_touched_nxt;
      dimmer_touched_r   <= dimmer_touched_nxt;
      power_event_seen_r <= power_event_seen_nxt;
      power_on_r         <= power_on_nxt;
      dim_level_r        <= dim_level_nxt;
      busy_r             <= busy_nxt;
      pw_r               <= pw_nxt;
      generation_r       <= generation_nxt;
      pulse_total_r      <= pulse_total_nxt;
      up_total_r         <= up_total_nxt;
      down_total_r       <= down_total_nxt;
    end
  end

  // ---------------- view and output register
  view_state_t vst;
  logic [1:0]  v_mode;
  logic        v_powered;
  logic [5:0]  v_level;
  logic [7:0]  v_intensity;

  assign vst = '{
    dimmer_touched:   dimmer_touched_nxt,
    pwm_touched:      pwm_touched_nxt,
    power_event_seen: power_event_seen_nxt,
    power_on:         power_on_nxt,
    dim_level:        dim_level_nxt,
    pwm_en:           pw_nxt[PWM_EN_BIT],
    duty:             pw_nxt[23:16]
  };

  bpdc_view u_view (
    .st        (vst),
    .mode      (v_mode),
    .powered   (v_powered),
    .level     (v_level),
    .intensity (v_intensity)
  );

  logic      out_valid_r;
  out_word_t out_word_r;

  assign out_ready = !out_valid_r || !out_stall;
  assign s1_fire   = s1_vld_r && out_ready;
  assign in_stall  = s1_vld_r && !s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_word_r.read_data    <= rd;
      out_word_r.mode         <= v_mode;
      out_word_r.powered      <= v_powered;
      out_word_r.level        <= v_level;
      out_word_r.intensity    <= v_intensity;
      out_word_r.change_count <= generation_nxt;
      out_word_r.pulse_count  <= pulse_total_nxt;
      out_word_r.up_count     <= up_total_nxt;
      out_word_r.down_count   <= down_total_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // ---------------- assertions
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.level <= MAX_LEVEL)
    else $error("level above 32");

  a_intensity_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_word.intensity == 8'd0) ==
                   (!out_word.powered || out_word.level == 6'd0)))
    else $error("intensity inconsistent with power and level");

  a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_vld_r && out_valid_r && out_stall)
    else $error("input stalled with free pipeline");

  a_status_write_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_cmd_r == CMD_DIM_WR && s1_dok_r && s1_is_stat_r |=> !busy_r)
    else $error("busy not cleared by status write");

  a_pulse_counts: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_pulse_r |=> pulse_total_r == $past(pulse_total_r) + 32'd1 && busy_r)
    else $error("start pulse not recorded");

endmodule

// File: hw/rtl/bpdc_ram.sv
// ----------------------------------------------------------------------------
// bpdc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bpdc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/bpdc_view.sv
// ----------------------------------------------------------------------------
// bpdc_view
// Backlight view: mode, power, level 0..32 and intensity from controller
// state.
// ----------------------------------------------------------------------------
module bpdc_view (
  input  bpdc_pkg::view_state_t st,
  output logic [1:0]            mode,
  output logic                  powered,
  output logic [5:0]            level,
  output logic [7:0]            intensity
);
  import bpdc_pkg::*;

  logic [13:0] scaled;
  logic [13:0] quot_sum;
  logic [5:0]  duty_level;
  logic [13:0] slope_prod;

  // (duty*32+127)/255 via x/255 = (x + (x>>8) + 1) >> 8, exact for 14-bit x
  assign scaled     = {1'b0, st.duty, 5'b00000} + DUTY_ROUND;
  assign quot_sum   = scaled + (scaled >> 8) + 14'd1;
  assign duty_level = (st.duty <= DUTY_DIRECT) ? st.duty[5:0] : quot_sum[13:8];

  always_comb begin
    if (st.dimmer_touched || st.power_event_seen) begin
      mode    = MODE_DIMMER;
      powered = st.power_event_seen && st.power_on;
    end else if (st.pwm_touched) begin
      mode    = MODE_PWM;
      powered = st.pwm_en && (st.duty != 8'd0);
    end else begin
      mode    = MODE_DEFAULT;
      powered = 1'b1;
    end

    if (st.dimmer_touched) begin
      level = st.dim_level;
    end else if (st.pwm_touched) begin
      level = duty_level;
    end else begin
      level = MAX_LEVEL;
    end
  end

  assign slope_prod = 14'(level) * 14'(INTEN_SLOPE);
  assign intensity  = (!powered || level == 6'd0) ? 8'd0 : INTEN_BASE + slope_prod[12:5];

endmodule

// File: test/backlight_pwm_dimmer_controller_unit_tb.sv
// ----------------------------------------------------------------------------
// backlight_pwm_dimmer_controller_unit_tb
// Drives register accesses and GPIO events into the controller and checks
// every result word against a shadow copy of both banks and the dimmer state.
// ----------------------------------------------------------------------------
module backlight_pwm_dimmer_controller_unit_tb;
  import bpdc_pkg::*;

  localparam int PWM_WORDS      = 8;
  localparam int DIM_WORDS      = 16;
  localparam int PHASE_WORDS    = 300;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 8;

  localparam logic [2:0]  CMD_UNUSED    = 3'd7;
  localparam logic [2:0]  SZ_BYTE       = 3'd1;
  localparam logic [2:0]  SZ_HALF       = 3'd2;
  localparam logic [2:0]  SZ_WORD       = 3'd4;
  localparam logic [15:0] PWM_BL_OFF    = {PWM_BL_IDX, 2'b00};
  localparam logic [15:0] DIM_CFG_OFF   = {DIM_CFG_IDX, 2'b00};
  localparam logic [15:0] DIM_STAT_OFF  = {DIM_STAT_IDX, 2'b00};
  localparam logic [5:0]  CH8_WIDTH_IDX = DIM_WIDTH_IDX + DIM_CHAN[7:3];
  localparam logic [15:0] CH8_WIDTH_OFF = {8'd0, CH8_WIDTH_IDX, 2'b00};
  localparam logic [31:0] START_MASK    = 32'h1 << DIM_START_BIT;
  localparam logic [31:0] BL_MASK       = 32'h1 << GPIO_BL_BIT;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  class bl_shadow;
    logic [31:0] pwm_mirror [PWM_WORDS];
    logic [31:0] dim_regs [DIM_WORDS];
    bit          pwm_touched, dim_touched, pwr_seen, pwr_on, busy_armed;
    bit          hit_top, hit_floor;
    logic [5:0]  dim_lvl;
    logic [31:0] gen, pulses, ups, downs;
    out_word_t   pending_views[$];
    int unsigned mismatches, checked;

    function new();
      foreach (pwm_mirror[i]) pwm_mirror[i] = '0;
      foreach (dim_regs[i]) dim_regs[i] = '0;
      pwm_touched = 0; dim_touched = 0; pwr_seen = 0; pwr_on = 0; busy_armed = 0;
      hit_top = 0; hit_floor = 0;
      dim_lvl = '0;
      gen = '0; pulses = '0; ups = '0; downs = '0;
      mismatches = 0; checked = 0;
    endfunction

    function logic [31:0] lanes(logic [2:0] sz);
      case (sz)
        SZ_BYTE: return 32'h0000_00ff;
        SZ_HALF: return 32'h0000_ffff;
        default: return 32'hffff_ffff;
      endcase
    endfunction

    function void fire_pulse(logic [31:0] cfg);
      int unsigned widx;
      logic [31:0] width;
      widx  = int'(DIM_WIDTH_IDX) + int'(cfg[7:3]);
      width = (widx < DIM_WORDS) ? dim_regs[widx] : '0;
      if (!dim_touched) dim_lvl = SEED_LEVEL;
      dim_touched = 1;
      pulses++;
      if (cfg[7:0] == DIM_CHAN && width == UP_WIDTH) begin
        if (dim_lvl < MAX_LEVEL) dim_lvl++;
        else hit_top = 1;
        ups++;
      end else if (cfg[7:0] == DIM_CHAN && width == DOWN_WIDTH) begin
        if (dim_lvl != 0) dim_lvl--;
        else hit_floor = 1;
        downs++;
      end
      dim_regs[DIM_STAT_IDX][DIM_BUSY_BIT] = 1'b1;
      busy_armed = 1;
      gen++;
    endfunction

    function void note_access(in_word_t w);
      int unsigned idx, lvl, inten;
      logic [4:0]  sh;
      logic [31:0] m, old, rd, pw;
      logic [7:0]  duty;
      bit          p, pow;
      out_word_t   e;
      idx = int'(w.offset[15:2]);
      sh  = {w.offset[1:0], 3'b000};
      m   = lanes(w.access_size) << sh;
      rd  = '0;
      case (w.command)
        CMD_PWM_RD: if (idx < PWM_WORDS) rd = (pwm_mirror[idx] >> sh) & lanes(w.access_size);
        CMD_PWM_WR: if (idx < PWM_WORDS) begin
          old = pwm_mirror[idx];
          pwm_mirror[idx] = (old & ~m) | ((w.write_data << sh) & m);
          if (idx == PWM_BL_IDX) begin
            pwm_touched = 1;
            if (old != pwm_mirror[idx]) gen++;
          end
        end
        CMD_DIM_RD: if (idx < DIM_WORDS) begin
          rd = (dim_regs[idx] >> sh) & lanes(w.access_size);
          // busy is reported once, then drops
          if (idx == DIM_STAT_IDX && busy_armed) begin
            busy_armed = 0;
            dim_regs[idx][DIM_BUSY_BIT] = 1'b0;
          end
        end
        CMD_DIM_WR: if (idx < DIM_WORDS) begin
          if (idx == DIM_STAT_IDX) begin
            dim_regs[idx][DIM_BUSY_BIT] = 1'b0;
            busy_armed = 0;
          end else begin
            old = dim_regs[idx];
            dim_regs[idx] = (old & ~m) | ((w.write_data << sh) & m);
            if (idx == DIM_CFG_IDX && !old[DIM_START_BIT] && dim_regs[idx][DIM_START_BIT])
              fire_pulse(dim_regs[idx]);
          end
        end
        CMD_GPIO_EV: if (w.gpio_addr == GPIO_OUT_REG && w.gpio_write_mask[GPIO_BL_BIT]) begin
          p = w.gpio_output_value[GPIO_BL_BIT];
          if (!pwr_seen || p != pwr_on) gen++;
          pwr_seen = 1;
          pwr_on   = p;
        end
        default: ;
      endcase

      pw   = pwm_mirror[PWM_BL_IDX];
      duty = pw[23:16];
      if (dim_touched || pwr_seen) begin
        e.mode = MODE_DIMMER;
        pow    = pwr_seen && pwr_on;
      end else if (pwm_touched) begin
        e.mode = MODE_PWM;
        pow    = pw[PWM_EN_BIT] && duty != 0;
      end else begin
        e.mode = MODE_DEFAULT;
        pow    = 1;
      end
      if (dim_touched) lvl = int'(dim_lvl);
      else if (pwm_touched)
        lvl = (duty <= DUTY_DIRECT) ? int'(duty)
                                    : (int'(duty) * 32 + int'(DUTY_ROUND)) / 255;
      else lvl = int'(MAX_LEVEL);
      if (lvl > MAX_LEVEL) lvl = int'(MAX_LEVEL);
      inten = (!pow || lvl == 0) ? 0 : int'(INTEN_BASE) + lvl * int'(INTEN_SLOPE) / 32;

      e.read_data    = rd;
      e.powered      = pow;
      e.level        = lvl[5:0];
      e.intensity    = inten[7:0];
      e.change_count = gen;
      e.pulse_count  = pulses;
      e.up_count     = ups;
      e.down_count   = downs;
      pending_views.push_back(e);
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch in %s of result %0d: expected %h, got %h", name, checked, want, got);
      end
    endfunction

    function void check_view(out_word_t got);
      out_word_t want;
      checked++;
      if (pending_views.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result %0d arrived with nothing outstanding: %h", checked, got);
        return;
      end
      want = pending_views.pop_front();
      cmp_field("read_data", want.read_data, got.read_data);
      cmp_field("mode", want.mode, got.mode);
      cmp_field("powered", want.powered, got.powered);
      cmp_field("level", want.level, got.level);
      cmp_field("intensity", want.intensity, got.intensity);
      cmp_field("change_count", want.change_count, got.change_count);
      cmp_field("pulse_count", want.pulse_count, got.pulse_count);
      cmp_field("up_count", want.up_count, got.up_count);
      cmp_field("down_count", want.down_count, got.down_count);
    endfunction
  endclass

  bl_shadow    shadow;
  int          tx_idle_pct  = 0;
  int          rx_idle_pct  = 0;
  int          holds_asked  = 0;
  int          holds_served = 0;
  int          hold_left    = 0;
  int          idle_cycles  = 0;
  int unsigned words_sent   = 0;

  backlight_pwm_dimmer_controller_unit #(
    .PWM_WORDS    (PWM_WORDS),
    .DIMMER_WORDS (DIM_WORDS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stall, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (holds_served != holds_asked) begin
      holds_served = holds_asked;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) shadow.check_view(out_word);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic in_word_t mk_acc(logic [2:0] cmd, logic [15:0] off, logic [2:0] sz,
                                      logic [31:0] d);
    in_word_t w;
    w.command           = cmd;
    w.offset            = off;
    w.access_size       = sz;
    w.write_data        = d;
    w.gpio_addr         = 12'($urandom);
    w.gpio_write_mask   = $urandom;
    w.gpio_output_value = $urandom;
    return w;
  endfunction

  function automatic in_word_t mk_gpio(logic [11:0] goff, logic [31:0] gmask, logic [31:0] gval);
    in_word_t w;
    w = mk_acc(CMD_GPIO_EV, 16'($urandom), 3'($urandom_range(1, 4)), $urandom);
    w.gpio_addr         = goff;
    w.gpio_write_mask   = gmask;
    w.gpio_output_value = gval;
    return w;
  endfunction

  // entered and left at a falling edge
  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    shadow.note_access(w);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (shadow.pending_views.size() != 0) @(negedge clk);
  endtask

  // one rising edge of the start bit, either as full words or as lane 3 bytes
  task automatic pulse_pair(logic [7:0] chan);
    logic [31:0] d;
    d = $urandom;
    if ($urandom_range(1)) begin
      d[DIM_START_BIT] = 1'b0;
      d[7:0] = chan;
      send_word(mk_acc(CMD_DIM_WR, DIM_CFG_OFF, SZ_WORD, d));
      d = $urandom;
      d[DIM_START_BIT] = 1'b1;
      d[7:0] = chan;
      send_word(mk_acc(CMD_DIM_WR, DIM_CFG_OFF, SZ_WORD, d));
    end else begin
      d[DIM_START_BIT-24] = 1'b0;
      send_word(mk_acc(CMD_DIM_WR, 16'(DIM_CFG_OFF + 3), SZ_BYTE, d));
      d = $urandom;
      d[DIM_START_BIT-24] = 1'b1;
      send_word(mk_acc(CMD_DIM_WR, 16'(DIM_CFG_OFF + 3), SZ_BYTE, d));
    end
  endtask

  task automatic directed_checks();
    send_word(mk_acc(CMD_PWM_RD, PWM_BL_OFF, SZ_WORD, '0));
    send_word(mk_acc(CMD_DIM_RD, 16'hffff, SZ_BYTE, '0));
    send_word(mk_acc(CMD_PWM_WR, PWM_BL_OFF, SZ_WORD, 32'h8000_0000));   // enabled, duty 0
    send_word(mk_acc(CMD_PWM_WR, 16'(PWM_BL_OFF + 2), SZ_BYTE, 32'd32));
    send_word(mk_acc(CMD_PWM_WR, 16'(PWM_BL_OFF + 2), SZ_BYTE, 32'd33));
    send_word(mk_acc(CMD_PWM_WR, 16'(PWM_BL_OFF + 2), SZ_HALF, 32'hffff_80ff));
    send_word(mk_acc(CMD_PWM_WR, 16'(PWM_BL_OFF + 3), SZ_WORD, 32'hffff_ff00)); // lane 3 only
    send_word(mk_acc(CMD_PWM_WR, 16'(PWM_BL_OFF + 3), SZ_BYTE, 32'h80));
    send_word(mk_acc(CMD_PWM_WR, 16'(PWM_BL_OFF + 2), SZ_BYTE, 32'd100));
    send_word(mk_acc(CMD_PWM_WR, 16'(PWM_WORDS * 4), SZ_WORD, '1));
    send_word(mk_acc(CMD_PWM_RD, 16'(PWM_BL_OFF + 3), SZ_WORD, '0));
    send_word(mk_acc(CMD_UNUSED, '1, '1, '1));
    send_word(mk_gpio(12'(GPIO_OUT_REG + 1), '1, '1));
    send_word(mk_gpio(GPIO_OUT_REG, ~BL_MASK, '1));
    send_word(mk_gpio(GPIO_OUT_REG, BL_MASK, BL_MASK));
    send_word(mk_gpio(GPIO_OUT_REG, '1, '1));                              // no power change
    send_word(mk_gpio(GPIO_OUT_REG, BL_MASK, ~BL_MASK));
    send_word(mk_gpio(GPIO_OUT_REG, BL_MASK, BL_MASK));
    send_word(mk_acc(CMD_DIM_WR, CH8_WIDTH_OFF, SZ_WORD, UP_WIDTH));
    send_word(mk_acc(CMD_DIM_WR, DIM_CFG_OFF, SZ_WORD, START_MASK | DIM_CHAN)); // seeds level
    send_word(mk_acc(CMD_DIM_RD, DIM_STAT_OFF, SZ_WORD, '0));
    send_word(mk_acc(CMD_DIM_RD, 16'(DIM_STAT_OFF + 3), SZ_BYTE, '0));
    send_word(mk_acc(CMD_DIM_WR, CH8_WIDTH_OFF, SZ_BYTE, DOWN_WIDTH));
    send_word(mk_acc(CMD_DIM_WR, 16'(DIM_CFG_OFF + 3), SZ_BYTE, '0));
    send_word(mk_acc(CMD_DIM_WR, 16'(DIM_CFG_OFF + 3), SZ_BYTE, START_MASK >> 24));
    send_word(mk_acc(CMD_DIM_WR, DIM_STAT_OFF, SZ_WORD, '1));
    send_word(mk_acc(CMD_DIM_WR, DIM_CFG_OFF, SZ_WORD, '0));
    // channel 80: its width word lies past the bank
    send_word(mk_acc(CMD_DIM_WR, DIM_CFG_OFF, SZ_WORD, START_MASK | 32'd80));
    send_word(mk_acc(CMD_DIM_WR, 16'hfffc, SZ_WORD, '1));
    send_word(mk_acc(CMD_DIM_RD, 16'(DIM_WORDS * 4 - 1), SZ_WORD, '0));
  endtask

  task automatic random_step();
    int unsigned pick, n, bank;
    logic [31:0] d;
    logic [15:0] off;
    logic [2:0]  c;
    pick = $urandom_range(99);
    if (pick < 30) begin
      // burst of level steps on channel 8, now and then another channel
      d = $urandom_range(1) ? UP_WIDTH : DOWN_WIDTH;
      if ($urandom_range(7) == 0) d = $urandom_range(3) == 0 ? $urandom : $urandom_range(130);
      send_word(mk_acc(CMD_DIM_WR, CH8_WIDTH_OFF, SZ_WORD, d));
      n = $urandom_range(1, 20);
      repeat (n) begin
        pulse_pair(($urandom_range(9) == 0) ? 8'($urandom_range(255)) : DIM_CHAN);
        if ($urandom_range(3) == 0) begin
          c = $urandom_range(1) ? CMD_DIM_RD : CMD_DIM_WR;
          send_word(mk_acc(c, 16'(DIM_STAT_OFF + $urandom_range(3)),
                           3'($urandom_range(1, 4)), $urandom));
        end
      end
    end else if (pick < 50) begin
      off = ($urandom_range(2) == 0) ? 16'(DIM_STAT_OFF + $urandom_range(3))
                                     : 16'($urandom_range(DIM_WORDS * 4 - 1));
      c = $urandom_range(1) ? CMD_DIM_RD : CMD_DIM_WR;
      send_word(mk_acc(c, off, 3'($urandom_range(1, 4)), $urandom));
    end else if (pick < 65) begin
      off = $urandom_range(1) ? 16'(PWM_BL_OFF + $urandom_range(3))
                              : 16'($urandom_range(PWM_WORDS * 4 - 1));
      c = $urandom_range(1) ? CMD_PWM_RD : CMD_PWM_WR;
      send_word(mk_acc(c, off, 3'($urandom_range(1, 4)), $urandom));
    end else if (pick < 80) begin
      d = $urandom;
      if ($urandom_range(9) < 7) d[GPIO_BL_BIT] = 1'b1;
      send_word(mk_gpio(($urandom_range(3) != 0) ? GPIO_OUT_REG : 12'($urandom_range(4095)),
                        d, $urandom));
    end else if (pick < 90) begin
      send_word(mk_acc(3'($urandom_range(CMD_UNUSED)), 16'($urandom),
                       3'($urandom_range(7)), $urandom));
    end else begin
      c    = 3'($urandom_range(CMD_DIM_WR));
      bank = (c == CMD_PWM_RD || c == CMD_PWM_WR) ? PWM_WORDS * 4 : DIM_WORDS * 4;
      off  = $urandom_range(1) ? 16'(bank + $urandom_range(15))
                               : 16'($urandom_range(65535, bank));
      send_word(mk_acc(c, off, 3'($urandom_range(1, 4)), $urandom));
    end
  endtask

  initial begin
    int tx_pct [3];
    int rx_pct [3];
    int unsigned target, hold_at;
    tx_pct = '{16, 69, 0};
    rx_pct = '{69, 16, 0};
    shadow = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    directed_checks();
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = tx_pct[ph];
      rx_idle_pct = rx_pct[ph];
      target  = words_sent + PHASE_WORDS;
      hold_at = (ph == 2) ? words_sent + 100 : 0;
      while (words_sent < target) begin
        if (hold_at != 0 && words_sent >= hold_at) begin
          holds_asked++;
          hold_at = 0;
        end
        random_step();
      end
      // sender pauses here until the block has returned everything
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("run: %0d words in, %0d results checked, %0d mismatches",
             words_sent, shadow.checked, shadow.mismatches);
    $display("dimmer: %0d pulses, %0d up, %0d down, top clamp %0d, floor clamp %0d",
             shadow.pulses, shadow.ups, shadow.downs, shadow.hit_top, shadow.hit_floor);
    if (shadow.mismatches == 0 && shadow.pending_views.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
